// ===== src/psmp_pkg.sv =====
// shared types and character codes for the power status message parser
package psmp_pkg;

  // event codes carried with every result word
  typedef enum logic [2:0] {
    EV_BUSY     = 3'd0,
    EV_STATUS   = 3'd1,
    EV_SHUTDOWN = 3'd2,
    EV_PING     = 3'd3,
    EV_UP       = 3'd4,
    EV_DOWN     = 3'd5,
    EV_ERROR    = 3'd6
  } psmp_event_t;

  // parser states
  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_WAIT_S     = 4'd1,
    ST_WAIT_P     = 4'd2,
    ST_WAIT_PLUS  = 4'd3,
    ST_WAIT_MINUS = 4'd4,
    ST_CHARGE     = 4'd5,
    ST_PERCENT    = 4'd6,
    ST_VOLTAGE    = 4'd7,
    ST_CURRENT    = 4'd8
  } psmp_state_t;

  // charge codes
  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_ON   = 2'd1,
    CHG_FULL = 2'd2
  } psmp_charge_t;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_COMMA = 8'h2c;

endpackage

// ===== src/psmp_in_if.sv =====
// byte input channel of the power status message parser
interface psmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/psmp_out_if.sv =====
// result channel of the power status message parser
interface psmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        online;
  logic [1:0]  charge_state;
  logic [7:0]  percent;
  logic [15:0] voltage;
  logic [15:0] current;

  modport source (output valid, output event_res, output online, output charge_state,
                  output percent, output voltage, output current, input ready);
  modport sink   (input valid, input event_res, input online, input charge_state,
                  input percent, input voltage, input current, output ready);
endinterface

// ===== src/power_status_message_parser.sv =====
// top level: byte-wise parser for power manager status and command messages
//
//  channel | dir | words                 | payload
//  --------+-----+-----------------------+------------------------------------------
//  in_ch   | in  | one rx byte per word  | rx_byte
//  out_ch  | out | one result per byte   | event_res, online, charge_state,
//          |     |                       | percent, voltage, current
//
// one word per cycle sustained while out_ch.ready holds; a byte taken into the input
// register is decoded into the result register, from which its result word leaves
// synchronous active-low reset puts the parser in idle with a cleared record
// a stalled result holds; the input register still takes a byte while it is empty
// in_ch.ready follows out_ch.ready combinationally through the two stages
module power_status_message_parser (
  input logic    clk,
  input logic    rst_n,
  psmp_in_if.sink    in_ch,
  psmp_out_if.source out_ch
);
  import psmp_pkg::*;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // result register
  logic        out_vld_r;
  psmp_event_t out_ev_r;
  logic        out_online_r;
  logic [1:0]  out_chg_r;
  logic [7:0]  out_pct_r;
  logic [15:0] out_volt_r;
  logic [15:0] out_cur_r;

  // parser state and status record
  psmp_state_t st_r, st_nxt;
  logic        online_r, online_nxt;
  logic [1:0]  chg_r, chg_nxt;
  logic [7:0]  pct_r, pct_nxt;
  logic [15:0] volt_r, volt_nxt;
  logic [15:0] cur_r, cur_nxt;
  psmp_event_t ev;

  logic       adv;      // input register hands its byte to the result register
  logic       is_dig;
  logic       is_nl;
  logic [3:0] dig;
  logic [7:0] b;

  assign b      = in_byte_r;
  assign is_dig = (b inside {[CH_0:CH_9]});
  assign is_nl  = (b == CH_NL);
  assign dig    = b[3:0];

  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  // next parser state
  always_comb begin
    st_nxt = ST_IDLE;
    case (st_r)
      ST_WAIT_S, ST_WAIT_P, ST_WAIT_PLUS, ST_WAIT_MINUS: begin
        st_nxt = ST_IDLE;
      end
      ST_CHARGE: begin
        if (b == CH_N || b == CH_C || b == CH_F) st_nxt = ST_PERCENT;
      end
      ST_PERCENT: begin
        if (is_dig) st_nxt = ST_PERCENT;
        else if (b == CH_COMMA) st_nxt = ST_VOLTAGE;
      end
      ST_VOLTAGE: begin
        if (is_dig) st_nxt = ST_VOLTAGE;
        else if (b == CH_COMMA) st_nxt = ST_CURRENT;
      end
      ST_CURRENT: begin
        if (is_dig) st_nxt = ST_CURRENT;
      end
      default: begin
        // idle, and unused codes behave as idle
        case (b)
          CH_0, CH_1: st_nxt = ST_CHARGE;
          CH_S:       st_nxt = ST_WAIT_S;
          CH_P:       st_nxt = ST_WAIT_P;
          CH_PLUS:    st_nxt = ST_WAIT_PLUS;
          CH_MINUS:   st_nxt = ST_WAIT_MINUS;
          default:    st_nxt = ST_IDLE;
        endcase
      end
    endcase
  end

  // event code and record updates
  always_comb begin
    ev         = EV_BUSY;
    online_nxt = online_r;
    chg_nxt    = chg_r;
    pct_nxt    = pct_r;
    volt_nxt   = volt_r;
    cur_nxt    = cur_r;
    case (st_r)
      ST_WAIT_S:     ev = is_nl ? EV_SHUTDOWN : EV_ERROR;
      ST_WAIT_P:     ev = is_nl ? EV_PING : EV_ERROR;
      ST_WAIT_PLUS:  ev = is_nl ? EV_UP : EV_ERROR;
      ST_WAIT_MINUS: ev = is_nl ? EV_DOWN : EV_ERROR;
      ST_CHARGE: begin
        case (b)
          CH_N:    chg_nxt = CHG_NONE;
          CH_C:    chg_nxt = CHG_ON;
          CH_F:    chg_nxt = CHG_FULL;
          default: ev = EV_ERROR;
        endcase
      end
      ST_PERCENT: begin
        // acc * 10 + digit as two shifts and adds, wrapping at the field width
        if (is_dig) pct_nxt = 8'((pct_r << 3) + (pct_r << 1) + {4'd0, dig});
        else if (b != CH_COMMA) ev = EV_ERROR;
      end
      ST_VOLTAGE: begin
        if (is_dig) volt_nxt = 16'((volt_r << 3) + (volt_r << 1) + {12'd0, dig});
        else if (b != CH_COMMA) ev = EV_ERROR;
      end
      ST_CURRENT: begin
        if (is_dig) cur_nxt = 16'((cur_r << 3) + (cur_r << 1) + {12'd0, dig});
        else if (is_nl) ev = EV_STATUS;
        else ev = EV_ERROR;
      end
      default: begin
        case (b)
          CH_0, CH_1: begin
            // message start clears the record
            online_nxt = b[0];
            chg_nxt    = CHG_NONE;
            pct_nxt    = '0;
            volt_nxt   = '0;
            cur_nxt    = '0;
          end
          CH_S, CH_P, CH_PLUS, CH_MINUS: ev = EV_BUSY;
          default: ev = EV_ERROR;
        endcase
      end
    endcase
  end

  // control and record registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= ST_IDLE;
      online_r  <= 1'b0;
      chg_r     <= CHG_NONE;
      pct_r     <= '0;
      volt_r    <= '0;
      cur_r     <= '0;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (adv) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
        online_r  <= online_nxt;
        chg_r     <= chg_nxt;
        pct_r     <= pct_nxt;
        volt_r    <= volt_nxt;
        cur_r     <= cur_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_byte_r <= in_ch.rx_byte;
    if (adv) begin
      out_ev_r     <= ev;
      out_online_r <= online_nxt;
      out_chg_r    <= chg_nxt;
      out_pct_r    <= pct_nxt;
      out_volt_r   <= volt_nxt;
      out_cur_r    <= cur_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.event_res    = out_ev_r;
  assign out_ch.online       = out_online_r;
  assign out_ch.charge_state = out_chg_r;
  assign out_ch.percent      = out_pct_r;
  assign out_ch.voltage      = out_volt_r;
  assign out_ch.current      = out_cur_r;

endmodule

// ===== src/psmp_checker.sv =====
// port-level checks for the power status message parser, bound to the top level
module psmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [1:0]  charge_state
);
  import psmp_pkg::*;

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only defined event codes leave the block
  a_ev_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_res != 3'd7)
    else $error("undefined event code");

  // the charge field never carries the unused code
  a_chg_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> charge_state != 2'd3)
    else $error("undefined charge code");

  // with nothing coming in and the output free, the block drains to empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && out_ready ##1 !in_valid && out_ready |=> !out_valid)
    else $error("result appeared without an input byte");

endmodule

bind power_status_message_parser psmp_checker u_psmp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .charge_state (out_ch.charge_state)
);

// ===== tb/tb_power_status_message_parser.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the power status message parser
module tb_power_status_message_parser;
  import psmp_pkg::*;

  // one expected result word: event plus the status record after the byte
  typedef struct packed {
    psmp_event_t  ev;
    logic         online;
    psmp_charge_t charge;
    logic [7:0]   pct;
    logic [15:0]  volt;
    logic [15:0]  curr;
  } status_word_t;

  // a byte to send, or a marker that makes the sender wait until all results are back
  typedef struct {
    logic [7:0] b;
    bit         drain;
  } plan_entry_t;

  logic clk;
  logic rst_n;

  psmp_in_if  in_ch ();
  psmp_out_if out_ch ();

  power_status_message_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  plan_entry_t  byte_plan[$];
  status_word_t status_words_due[$];

  int mismatch_count = 0;
  int bytes_taken    = 0;
  bit in_took        = 1'b0;
  bit hold_ready     = 1'b0;

  // sender and receiver pacing counters
  int burst_left = 0;
  int gap_left   = 0;
  int run_left   = 0;
  int stall_left = 0;

  // parser model state, same reset values as the block
  psmp_state_t  pstate      = ST_IDLE;
  logic         rec_online  = 1'b0;
  psmp_charge_t rec_charge  = CHG_NONE;
  logic [7:0]   rec_pct     = 8'h00;
  logic [15:0]  rec_volt    = 16'h0000;
  logic [15:0]  rec_curr    = 16'h0000;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reset once at the start; the driver and receiver quiet the channels during it
  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit is_dec(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // advance the parser model by one byte and return the word it must produce
  function automatic status_word_t next_status_word(input logic [7:0] b);
    psmp_event_t ev;
    ev = EV_BUSY;
    case (pstate)
      ST_WAIT_S:     ev = (b == CH_NL) ? EV_SHUTDOWN : EV_ERROR;
      ST_WAIT_P:     ev = (b == CH_NL) ? EV_PING : EV_ERROR;
      ST_WAIT_PLUS:  ev = (b == CH_NL) ? EV_UP : EV_ERROR;
      ST_WAIT_MINUS: ev = (b == CH_NL) ? EV_DOWN : EV_ERROR;
      ST_CHARGE: begin
        if (b == CH_N) begin
          rec_charge = CHG_NONE;
          pstate     = ST_PERCENT;
        end else if (b == CH_C) begin
          rec_charge = CHG_ON;
          pstate     = ST_PERCENT;
        end else if (b == CH_F) begin
          rec_charge = CHG_FULL;
          pstate     = ST_PERCENT;
        end else begin
          ev = EV_ERROR;
        end
      end
      // digit runs accumulate with wraparound at the field width
      ST_PERCENT: begin
        if (is_dec(b)) rec_pct = rec_pct * 8'd10 + {4'h0, b[3:0]};
        else if (b == CH_COMMA) pstate = ST_VOLTAGE;
        else ev = EV_ERROR;
      end
      ST_VOLTAGE: begin
        if (is_dec(b)) rec_volt = rec_volt * 16'd10 + {12'h000, b[3:0]};
        else if (b == CH_COMMA) pstate = ST_CURRENT;
        else ev = EV_ERROR;
      end
      ST_CURRENT: begin
        if (is_dec(b)) rec_curr = rec_curr * 16'd10 + {12'h000, b[3:0]};
        else if (b == CH_NL) ev = EV_STATUS;
        else ev = EV_ERROR;
      end
      default: begin
        // online digit starts a status message and clears the record
        if (b == CH_0 || b == CH_1) begin
          rec_charge = CHG_NONE;
          rec_pct    = 8'h00;
          rec_volt   = 16'h0000;
          rec_curr   = 16'h0000;
          rec_online = b[0];
          pstate     = ST_CHARGE;
        end else if (b == CH_S) begin
          pstate = ST_WAIT_S;
        end else if (b == CH_P) begin
          pstate = ST_WAIT_P;
        end else if (b == CH_PLUS) begin
          pstate = ST_WAIT_PLUS;
        end else if (b == CH_MINUS) begin
          pstate = ST_WAIT_MINUS;
        end else begin
          ev = EV_ERROR;
        end
      end
    endcase
    // any finished event, good or bad, drops back to idle; record is kept
    if (ev != EV_BUSY) pstate = ST_IDLE;
    return '{ev, rec_online, rec_charge, rec_pct, rec_volt, rec_curr};
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // monitor: check result words, and predict for every byte word taken
  always @(posedge clk) begin
    status_word_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_words_due.size() == 0) begin
          $error("result word with none expected: event_res %0d", out_ch.event_res);
          mismatch_count++;
        end else begin
          want = status_words_due.pop_front();
          check_field("event_res", 16'(want.ev), 16'(out_ch.event_res));
          check_field("online", 16'(want.online), 16'(out_ch.online));
          check_field("charge_state", 16'(want.charge), 16'(out_ch.charge_state));
          check_field("percent", 16'(want.pct), 16'(out_ch.percent));
          check_field("voltage", want.volt, out_ch.voltage);
          check_field("current", want.curr, out_ch.current);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        status_words_due.push_back(next_status_word(in_ch.rx_byte));
        in_took = 1'b1;
        bytes_taken++;
      end
    end
  end

  // driver: offer bytes in bursts with gaps, honor drain markers
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (byte_plan.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (byte_plan[0].drain) begin
        // stay quiet until every outstanding result has come back
        in_ch.valid <= 1'b0;
        if (status_words_due.size() == 0) void'(byte_plan.pop_front());
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= byte_plan.pop_front().b;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // mostly short bursts, now and then a long run with no gap
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(60, 150);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // receiver: its own run/stall pattern, plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_ready) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(0, 12);
        stall_left = $urandom_range(0, 6);
      end
    end
  end

  // long receiver hold-off while the sender keeps going, so the input backs up
  initial begin
    while (bytes_taken < 500) @(posedge clk);
    hold_ready = 1'b1;
    repeat (300) @(posedge clk);
    hold_ready = 1'b0;
  end

  task automatic push_byte(input logic [7:0] b);
    byte_plan.push_back('{b, 1'b0});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic append_digits(ref logic [7:0] msg[$], input int n);
    for (int i = 0; i < n; i++) msg.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  // status message with random content; broken ones are cut short and end in a random byte
  task automatic push_status(input bit broken);
    logic [7:0] msg[$];
    int         cut;
    msg.push_back($urandom_range(0, 1) ? CH_1 : CH_0);
    case ($urandom_range(0, 2))
      0:       msg.push_back(CH_N);
      1:       msg.push_back(CH_C);
      default: msg.push_back(CH_F);
    endcase
    append_digits(msg, $urandom_range(0, 3));
    msg.push_back(CH_COMMA);
    append_digits(msg, ($urandom_range(0, 4) == 0) ? $urandom_range(6, 7)
                                                   : $urandom_range(0, 5));
    msg.push_back(CH_COMMA);
    append_digits(msg, ($urandom_range(0, 4) == 0) ? $urandom_range(6, 7)
                                                   : $urandom_range(0, 5));
    msg.push_back(CH_NL);
    if (broken) begin
      cut = $urandom_range(0, msg.size() - 1);
      for (int i = 0; i < cut; i++) push_byte(msg[i]);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      foreach (msg[i]) push_byte(msg[i]);
    end
  endtask

  task automatic push_short_msg();
    case ($urandom_range(0, 3))
      0:       push_byte(CH_S);
      1:       push_byte(CH_P);
      2:       push_byte(CH_PLUS);
      default: push_byte(CH_MINUS);
    endcase
    push_byte(CH_NL);
  endtask

  // stimulus plan and end of run
  initial begin
    int  pick;
    bit  drained;
    drained = 1'b0;

    // directed: empty numbers, every short message, wrapping fields,
    // bytes at the ends of the range, errors mid-message
    push_text("0n,,\n");
    push_text("s\n");
    push_text("p\n");
    push_text("+\n");
    push_text("-\n");
    push_text("1f999,99999,\n");
    push_byte(8'hff);
    push_byte(8'h00);
    push_text("1c");
    push_byte(8'h80);
    byte_plan.push_back('{8'h00, 1'b1});

    // random: mostly well-formed messages, some broken ones and noise
    while (byte_plan.size() < 1300) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) push_status(1'b0);
      else if (pick < 75) push_short_msg();
      else if (pick < 90) push_status(1'b1);
      else push_byte(8'($urandom_range(0, 255)));
      if (!drained && byte_plan.size() >= 800) begin
        byte_plan.push_back('{8'h00, 1'b1});
        drained = 1'b1;
      end
    end

    // wait for the last byte word, then for every result, then a little more
    while (byte_plan.size() != 0 || in_ch.valid !== 1'b0) @(posedge clk);
    while (status_words_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", status_words_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
src/psmp_pkg.sv
src/psmp_in_if.sv
src/psmp_out_if.sv
src/power_status_message_parser.sv
src/psmp_checker.sv
tb/tb_power_status_message_parser.sv
